### hw/rtl/wavp_pkg.sv
// package for the wav riff header parser
// holds the parse phase type, chunk tags and status codes; no dependencies
package wavp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_CHUNK_HDR = 3'd1,
        PH_FMT       = 3'd2,
        PH_DATA      = 3'd3,
        PH_SKIP      = 3'd4,
        PH_PAD       = 3'd5,
        PH_DONE      = 3'd6,
        PH_ERROR     = 3'd7
    } phase_t;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [2:0] ST_PARSING    = 3'd0;
    localparam logic [2:0] ST_OK         = 3'd1;
    localparam logic [2:0] ST_NOT_WAVE   = 3'd2;
    localparam logic [2:0] ST_MISSING    = 3'd3;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd4;
    localparam logic [2:0] ST_TRUNCATED  = 3'd5;

    localparam logic [15:0] WANT_FORMAT   = 16'd1;
    localparam logic [15:0] WANT_CHANNELS = 16'd2;
    localparam logic [31:0] WANT_RATE     = 32'd44100;
    localparam logic [15:0] WANT_BITS     = 16'd16;

    localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
    localparam logic [31:0] FMT_CHECK_LEN = 32'd40;
    localparam logic [31:0] HEADER_LEN    = 32'd12;
    localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;

    localparam int OUT_BITS = 8 + 3 + 32;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

### hw/rtl/wav_riff_header_parser.sv
// top level of the wav riff header parser
// depends on wavp_pkg; one result transfer per input byte
//
// Takes a WAV file one byte per transfer on s_axis (tlast on the final byte)
// and returns one registered transfer on m_axis for every byte. tuser
// flags data chunk payload, which is passed in tdata[7:0]; tdata[10:8] is 0
// until the final byte, where it gives the verdict (1 ok, 2 not riff/wave,
// 3 fmt or data missing, 4 not 44.1 kHz 16-bit stereo pcm, 5 truncated), and
// tdata[42:11] is the size of the first data chunk. A byte is taken every
// cycle; the single output register sets the rate, and s_axis_tready only
// drops while that register holds a result that m_axis has not taken. After
// the final byte the parser is back in its reset state for the next file.
module wav_riff_header_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // in_byte
    input  logic                             s_axis_tlast,   // end_of_file
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // audio_byte [7:0], status [10:8], data_length [42:11], zero fill
    output logic [wavp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                             m_axis_tuser    // audio_valid
);
    import wavp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next, pos_inc;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_fmt_reg, seen_fmt_next;
    logic        seen_data_reg, seen_data_next;
    logic [31:0] data_len_reg, data_len_next;
    logic        not_riff_reg, not_riff_next;

    logic        m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic        m_user_reg;

    logic        accept;
    logic        hdr_done;
    logic        chunk_end;
    logic        audio;
    logic [31:0] fmt_need;
    logic [2:0]  verdict;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pos_inc       = pos_reg + 32'd1;

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        format_next    = format_reg;
        chans_next     = chans_reg;
        rate_next      = rate_reg;
        bits_next      = bits_reg;
        seen_fmt_next  = seen_fmt_reg;
        seen_data_next = seen_data_reg;
        data_len_next  = data_len_reg;
        not_riff_next  = not_riff_reg;
        hdr_done       = 1'b0;
        chunk_end      = 1'b0;
        audio          = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                if (pos_reg < 32'd4 || pos_reg >= 32'd8) begin
                    tag_next = {tag_reg[23:0], s_axis_tdata};
                end
                if (pos_reg == 32'd3 && tag_next != TAG_RIFF) begin
                    not_riff_next = 1'b1;
                end
                pos_next = pos_inc;
                if (pos_inc == HEADER_LEN) begin
                    if (tag_next != TAG_WAVE || not_riff_next) begin
                        not_riff_next = 1'b1;
                        phase_next    = PH_ERROR;
                    end else begin
                        phase_next = PH_CHUNK_HDR;
                    end
                    pos_next = '0;
                    tag_next = '0;
                end
            end
            PH_CHUNK_HDR: begin
                if (pos_reg < 32'd4) begin
                    tag_next = {tag_reg[23:0], s_axis_tdata};
                end else begin
                    case (pos_reg[1:0])
                        2'd0:    len_next = {24'd0, s_axis_tdata};
                        2'd1:    len_next[15:8] = s_axis_tdata;
                        2'd2:    len_next[23:16] = s_axis_tdata;
                        default: len_next[31:24] = s_axis_tdata;
                    endcase
                end
                pos_next = pos_inc;
                if (pos_inc == CHUNK_HDR_LEN) begin
                    hdr_done = 1'b1;
                end
            end
            PH_FMT: begin
                if (len_reg >= FMT_MIN_LEN && pos_reg < FMT_MIN_LEN) begin
                    case (pos_reg[3:0])
                        4'd0:    format_next = {8'd0, s_axis_tdata};
                        4'd1:    format_next[15:8] = s_axis_tdata;
                        4'd2:    chans_next = {8'd0, s_axis_tdata};
                        4'd3:    chans_next[15:8] = s_axis_tdata;
                        4'd4:    rate_next = {24'd0, s_axis_tdata};
                        4'd5:    rate_next[15:8] = s_axis_tdata;
                        4'd6:    rate_next[23:16] = s_axis_tdata;
                        4'd7:    rate_next[31:24] = s_axis_tdata;
                        4'd14:   bits_next = {8'd0, s_axis_tdata};
                        4'd15:   bits_next[15:8] = s_axis_tdata;
                        default: ;
                    endcase
                end
                pos_next = pos_inc;
                if (len_reg >= FMT_MIN_LEN && pos_inc == FMT_MIN_LEN) begin
                    seen_fmt_next = 1'b1;
                end
                if (pos_inc == len_reg) begin
                    chunk_end = 1'b1;
                end
            end
            PH_DATA: begin
                audio    = 1'b1;
                pos_next = pos_inc;
                if (pos_inc == len_reg) begin
                    chunk_end = 1'b1;
                end
            end
            PH_SKIP: begin
                pos_next = pos_inc;
                if (pos_inc == len_reg) begin
                    chunk_end = 1'b1;
                end
            end
            PH_PAD: begin
                phase_next = PH_CHUNK_HDR;
                pos_next   = '0;
                tag_next   = '0;
            end
            default: ;
        endcase

        if (hdr_done) begin
            pos_next = '0;
            if (tag_next == TAG_FMT) begin
                phase_next = PH_FMT;
            end else if (tag_next == TAG_DATA && !seen_data_reg) begin
                seen_data_next = 1'b1;
                data_len_next  = len_next;
                phase_next     = PH_DATA;
            end else begin
                phase_next = PH_SKIP;
            end
            if (len_next == '0) begin
                chunk_end = 1'b1;
            end
        end

        if (chunk_end) begin
            if (seen_fmt_next && seen_data_next) begin
                phase_next = PH_DONE;
            end else if (len_next[0]) begin
                phase_next = PH_PAD;
            end else begin
                phase_next = PH_CHUNK_HDR;
            end
            pos_next = '0;
            tag_next = '0;
        end

        fmt_need = (len_next < FMT_CHECK_LEN) ? len_next : FMT_CHECK_LEN;
        if (phase_next == PH_ERROR) begin
            verdict = ST_NOT_WAVE;
        end else if (phase_next == PH_HEADER || phase_next == PH_DATA) begin
            verdict = ST_TRUNCATED;
        end else if (phase_next == PH_FMT && pos_next < fmt_need) begin
            verdict = ST_TRUNCATED;
        end else if (!seen_fmt_next || !seen_data_next) begin
            verdict = ST_MISSING;
        end else if (format_next != WANT_FORMAT || chans_next != WANT_CHANNELS ||
                     rate_next != WANT_RATE || bits_next != WANT_BITS) begin
            verdict = ST_BAD_FORMAT;
        end else begin
            verdict = ST_OK;
        end
    end

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_axis_tlast)) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            tag_reg       <= '0;
            len_reg       <= '0;
            format_reg    <= '0;
            chans_reg     <= '0;
            rate_reg      <= '0;
            bits_reg      <= '0;
            seen_fmt_reg  <= 1'b0;
            seen_data_reg <= 1'b0;
            data_len_reg  <= '0;
            not_riff_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            tag_reg       <= tag_next;
            len_reg       <= len_next;
            format_reg    <= format_next;
            chans_reg     <= chans_next;
            rate_reg      <= rate_next;
            bits_reg      <= bits_next;
            seen_fmt_reg  <= seen_fmt_next;
            seen_data_reg <= seen_data_next;
            data_len_reg  <= data_len_next;
            not_riff_reg  <= not_riff_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_user_reg <= audio;
            m_data_reg <= {{(OUT_TDATA_W - OUT_BITS){1'b0}}, data_len_next,
                           (s_axis_tlast ? verdict : ST_PARSING),
                           (audio ? s_axis_tdata : 8'd0)};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

### hw/rtl/wavp_checker.sv
// port-level checks for the wav riff header parser
// depends on wavp_pkg; bound to wav_riff_header_parser below
module wavp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [7:0]                       s_axis_tdata,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [wavp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tuser
);
    import wavp_pkg::*;

    logic [7:0] in_seen;
    assign in_seen = s_axis_tdata;

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // empty output register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // every input transfer gives a result with the payload byte when flagged
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=>
            m_axis_tvalid && (!m_axis_tuser || m_axis_tdata[7:0] == $past(in_seen)))
        else $error("missing or wrong result for input transfer");

    // no verdict before the last byte, and only defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !s_axis_tlast |=>
            m_axis_tdata[10:8] == ST_PARSING)
        else $error("verdict on a byte that is not last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser || m_axis_tdata[7:0] == 8'd0) &&
            m_axis_tdata[10:8] <= ST_TRUNCATED)
        else $error("malformed result transfer");

endmodule

bind wav_riff_header_parser wavp_checker u_wavp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// testbench for wav_riff_header_parser: feeds whole wav files one byte per transfer
// and checks every result transfer against a byte-level parse model kept here
// depends on wavp_pkg and the wav_riff_header_parser rtl
module tb_top;
    import wavp_pkg::*;

    localparam int RANDOM_BYTES = 1100;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_LIMIT  = 5000;

    typedef struct packed {
        logic        audio_valid;
        logic [7:0]  audio_byte;
        logic [2:0]  status;
        logic [31:0] data_length;
    } parse_result_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       pinned;
        logic [2:0] st;
    } stim_row_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'h00;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    logic                   status_pin_en = 1'b0;
    logic [2:0]             status_pin    = ST_PARSING;

    wav_riff_header_parser i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // parse model state
    phase_t      ps_phase;
    logic [31:0] ps_pos, ps_tag, ps_len, ps_rate, ps_payload_len;
    logic [15:0] ps_format, ps_channels, ps_bits;
    logic        ps_seen_fmt, ps_seen_data;
    logic [2:0]  ps_verdict;

    parse_result_t parsed_bytes_q[$];
    logic [7:0]    wav_bytes[$];

    int mismatches, results_seen, bytes_in, audio_seen, files_sent, burst_left;
    int hold_requests, holds_done, hold_left, rx_mode_left, rx_tick;
    int verdict_seen[6];
    rx_mode_t rx_mode = RX_ALWAYS;

    stim_row_t directed_rows [0:25] = '{
        '{8'hFF, 1'b1, 1'b1, ST_TRUNCATED},
        '{8'h00, 1'b1, 1'b1, ST_TRUNCATED},
        '{8'h52, 1'b0, 1'b0, ST_PARSING},
        '{8'h49, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, ST_PARSING},
        '{8'h24, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, ST_PARSING},
        '{8'h00, 1'b0, 1'b0, ST_PARSING},
        '{8'h57, 1'b0, 1'b0, ST_PARSING},
        '{8'h41, 1'b0, 1'b0, ST_PARSING},
        '{8'h56, 1'b0, 1'b0, ST_PARSING},
        '{8'h45, 1'b1, 1'b1, ST_MISSING},
        '{8'h52, 1'b0, 1'b0, ST_PARSING},
        '{8'h49, 1'b0, 1'b0, ST_PARSING},
        '{8'h46, 1'b0, 1'b0, ST_PARSING},
        '{8'h58, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, ST_PARSING},
        '{8'hFF, 1'b0, 1'b0, ST_PARSING},
        '{8'h57, 1'b0, 1'b0, ST_PARSING},
        '{8'h41, 1'b0, 1'b0, ST_PARSING},
        '{8'h56, 1'b0, 1'b0, ST_PARSING},
        '{8'h45, 1'b1, 1'b1, ST_NOT_WAVE}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("wav_riff_header_parser: mismatch");
        $finish;
    end

    function automatic void parser_clear();
        ps_phase       = PH_HEADER;
        ps_pos         = '0;
        ps_tag         = '0;
        ps_len         = '0;
        ps_format      = '0;
        ps_channels    = '0;
        ps_rate        = '0;
        ps_bits        = '0;
        ps_seen_fmt    = 1'b0;
        ps_seen_data   = 1'b0;
        ps_payload_len = '0;
        ps_verdict     = ST_PARSING;
    endfunction

    function automatic void close_chunk();
        if (ps_seen_fmt && ps_seen_data) begin
            ps_phase = PH_DONE;
        end else if (ps_len[0]) begin
            ps_phase = PH_PAD;
        end else begin
            ps_phase = PH_CHUNK_HDR;
        end
        ps_pos = '0;
        ps_tag = '0;
    endfunction

    function automatic void open_chunk();
        ps_pos = '0;
        if (ps_tag == TAG_FMT) begin
            ps_phase = PH_FMT;
        end else if (ps_tag == TAG_DATA && !ps_seen_data) begin
            ps_seen_data   = 1'b1;
            ps_payload_len = ps_len;
            ps_phase       = PH_DATA;
        end else begin
            ps_phase = PH_SKIP;
        end
        if (ps_len == 0) close_chunk();
    endfunction

    function automatic void take_fmt_byte(input logic [7:0] b);
        if (ps_len >= FMT_MIN_LEN) begin
            case (ps_pos)
                32'd0:  ps_format   = {8'h00, b};
                32'd1:  ps_format   |= {b, 8'h00};
                32'd2:  ps_channels = {8'h00, b};
                32'd3:  ps_channels |= {b, 8'h00};
                32'd4:  ps_rate     = {24'h0, b};
                32'd5:  ps_rate     |= {16'h0, b, 8'h00};
                32'd6:  ps_rate     |= {8'h0, b, 16'h0};
                32'd7:  ps_rate     |= {b, 24'h0};
                32'd14: ps_bits     = {8'h00, b};
                32'd15: ps_bits     |= {b, 8'h00};
                default: ;
            endcase
        end
        ps_pos++;
        if (ps_len >= FMT_MIN_LEN && ps_pos == FMT_MIN_LEN) ps_seen_fmt = 1'b1;
        if (ps_pos == ps_len) close_chunk();
    endfunction

    function automatic logic [2:0] file_verdict();
        logic [31:0] need;
        if (ps_phase == PH_ERROR) return ST_NOT_WAVE;
        if (ps_phase == PH_HEADER || ps_phase == PH_DATA) return ST_TRUNCATED;
        if (ps_phase == PH_FMT) begin
            need = (ps_len < FMT_CHECK_LEN) ? ps_len : FMT_CHECK_LEN;
            if (ps_pos < need) return ST_TRUNCATED;
        end
        if (!ps_seen_fmt || !ps_seen_data) return ST_MISSING;
        if (!(ps_format == WANT_FORMAT && ps_channels == WANT_CHANNELS &&
              ps_rate == WANT_RATE && ps_bits == WANT_BITS)) return ST_BAD_FORMAT;
        return ST_OK;
    endfunction

    function automatic parse_result_t parse_byte(input logic [7:0] b, input logic last);
        parse_result_t r;
        r = '0;
        case (ps_phase)
            PH_HEADER: begin
                if (ps_pos < 4 || ps_pos >= 8) ps_tag = {ps_tag[23:0], b};
                if (ps_pos == 3 && ps_tag != TAG_RIFF) ps_verdict = ST_NOT_WAVE;
                ps_pos++;
                if (ps_pos == HEADER_LEN) begin
                    if (ps_tag != TAG_WAVE || ps_verdict == ST_NOT_WAVE) begin
                        ps_verdict = ST_NOT_WAVE;
                        ps_phase   = PH_ERROR;
                    end else begin
                        ps_phase = PH_CHUNK_HDR;
                    end
                    ps_pos = '0;
                    ps_tag = '0;
                end
            end
            PH_CHUNK_HDR: begin
                if (ps_pos < 4) begin
                    ps_tag = {ps_tag[23:0], b};
                end else if (ps_pos == 4) begin
                    ps_len = {24'h0, b};
                end else begin
                    ps_len = ps_len | (32'(b) << (8 * ((ps_pos - 4) & 3)));
                end
                ps_pos++;
                if (ps_pos == CHUNK_HDR_LEN) open_chunk();
            end
            PH_FMT: take_fmt_byte(b);
            PH_DATA: begin
                r.audio_valid = 1'b1;
                r.audio_byte  = b;
                ps_pos++;
                if (ps_pos == ps_len) close_chunk();
            end
            PH_SKIP: begin
                ps_pos++;
                if (ps_pos == ps_len) close_chunk();
            end
            PH_PAD: begin
                ps_phase = PH_CHUNK_HDR;
                ps_pos   = '0;
                ps_tag   = '0;
            end
            default: ;
        endcase
        if (last) begin
            ps_verdict = file_verdict();
            r.status   = ps_verdict;
        end
        r.data_length = ps_payload_len;
        if (last) parser_clear();
        return r;
    endfunction

    function automatic void put_tag(input logic [31:0] t);
        wav_bytes.push_back(t[31:24]);
        wav_bytes.push_back(t[23:16]);
        wav_bytes.push_back(t[15:8]);
        wav_bytes.push_back(t[7:0]);
    endfunction

    function automatic void put_le32(input logic [31:0] v);
        wav_bytes.push_back(v[7:0]);
        wav_bytes.push_back(v[15:8]);
        wav_bytes.push_back(v[23:16]);
        wav_bytes.push_back(v[31:24]);
    endfunction

    function automatic void put_chunk_body(input logic [31:0] len);
        for (int i = 0; i < len; i++) wav_bytes.push_back(8'($urandom));
        if (len[0]) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_fmt_chunk();
        logic [31:0]  size, rate;
        logic [15:0]  fmt_code, chans, bits;
        logic [127:0] head;
        int           pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) size = 16;
        else if (pick == 5) size = 18;
        else if (pick == 6) size = $urandom_range(0, 15);
        else if (pick == 7) size = 40;
        else if (pick == 8) size = 41;
        else size = $urandom_range(17, 24);
        fmt_code = WANT_FORMAT;
        chans    = WANT_CHANNELS;
        rate     = WANT_RATE;
        bits     = WANT_BITS;
        case ($urandom_range(0, 7))
            0: fmt_code = 16'($urandom);
            1: chans    = 16'($urandom_range(0, 3));
            2: rate     = $urandom;
            3: bits     = 16'($urandom);
            4: rate     = 32'd48000;
            default: ;
        endcase
        head = {bits, 16'($urandom), 32'($urandom), rate, chans, fmt_code};
        put_tag(TAG_FMT);
        put_le32(size);
        for (int i = 0; i < size; i++) begin
            wav_bytes.push_back(i < 16 ? head[8*i +: 8] : 8'($urandom));
        end
        if (size[0]) wav_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_plain_chunk(input logic [31:0] tag, input logic [31:0] len);
        put_tag(tag);
        put_le32(len);
        put_chunk_body(len);
    endfunction

    function automatic void put_any_chunk();
        case ($urandom_range(0, 2))
            0: put_fmt_chunk();
            1: put_plain_chunk(TAG_DATA, $urandom_range(0, 24));
            default: put_plain_chunk($urandom, $urandom_range(0, 9));
        endcase
    endfunction

    function automatic void build_file();
        int kind, idx, cut, n;
        bit data_first;
        wav_bytes.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
            return;
        end
        put_tag(TAG_RIFF);
        put_le32($urandom);
        put_tag(TAG_WAVE);
        if (kind == 1) begin
            wav_bytes = wav_bytes[0:$urandom_range(0, 10)];
            return;
        end
        if (kind == 2) begin
            idx = $urandom_range(0, 7);
            if (idx >= 4) idx += 4;
            wav_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
        end
        if (kind == 3) begin
            // chunk whose size runs past the end of the file
            case ($urandom_range(0, 2))
                0: put_tag(TAG_DATA);
                1: put_tag(TAG_FMT);
                default: put_tag($urandom);
            endcase
            put_le32($urandom);
            n = $urandom_range(0, 10);
            for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
            return;
        end
        if (kind < 6) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) put_any_chunk();
        end else begin
            data_first = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0) put_plain_chunk($urandom, $urandom_range(0, 9));
            if (data_first) put_plain_chunk(TAG_DATA, $urandom_range(0, 24));
            else put_fmt_chunk();
            if ($urandom_range(0, 2) == 0) put_plain_chunk($urandom, $urandom_range(0, 9));
            if (data_first) put_fmt_chunk();
            else put_plain_chunk(TAG_DATA, $urandom_range(0, 24));
            if ($urandom_range(0, 2) == 0) put_any_chunk();
        end
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) wav_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, wav_bytes.size());
            wav_bytes = wav_bytes[0:cut-1];
        end
    endfunction

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            s_axis_tlast  <= 1'b0;
        end
    endtask

    task automatic drive_byte(input logic [7:0] b, input logic last,
                              input logic pinned, input logic [2:0] pin);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        status_pin_en <= pinned;
        status_pin    <= pin;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_file(input bit steady);
        int gap;
        for (int i = 0; i < wav_bytes.size(); i++) begin
            if (!steady && burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) idle_cycles(gap);
                burst_left = $urandom_range(1, 30);
            end
            if (burst_left > 0) burst_left--;
            drive_byte(wav_bytes[i], i == wav_bytes.size() - 1, 1'b0, ST_PARSING);
        end
    endtask

    task automatic note_mismatch(input string what, input parse_result_t want,
                                 input parse_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s at result %0d: want valid %b byte %h status %0d length %h, got valid %b byte %h status %0d length %h",
                     what, results_seen, want.audio_valid, want.audio_byte, want.status,
                     want.data_length, got.audio_valid, got.audio_byte, got.status,
                     got.data_length);
        end
    endtask

    // receiver stall patterns and requested long hold-offs
    always @(negedge aclk) begin
        if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(10, 120);
            end
            rx_mode_left--;
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 0);
                RX_PERIODIC: m_axis_tready <= (rx_tick % 3 != 0);
                default:     m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        parse_result_t want, got;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = parse_byte(s_axis_tdata, s_axis_tlast);
                if (status_pin_en) want.status = status_pin;
                parsed_bytes_q.push_back(want);
                bytes_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8], m_axis_tdata[42:11]};
                if (parsed_bytes_q.size() == 0) begin
                    note_mismatch("unexpected transfer", '0, got);
                end else begin
                    want = parsed_bytes_q.pop_front();
                    if (got.audio_valid !== want.audio_valid || got.audio_byte !== want.audio_byte ||
                        got.status !== want.status || got.data_length !== want.data_length) begin
                        note_mismatch("mismatch", want, got);
                    end
                    if (want.audio_valid) audio_seen++;
                    if (want.status != ST_PARSING && want.status <= ST_TRUNCATED) begin
                        verdict_seen[want.status]++;
                    end
                end
                results_seen++;
            end
        end
    end

    initial begin
        int drain;
        bit steady;
        parser_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[r]) begin
            drive_byte(directed_rows[r].b, directed_rows[r].last,
                       directed_rows[r].pinned, directed_rows[r].st);
        end
        files_sent = 4;

        while (bytes_in < RANDOM_BYTES + $size(directed_rows)) begin
            build_file();
            if (files_sent == 6 || files_sent % 9 == 0) hold_requests++;
            steady = ($urandom_range(0, 3) == 0);
            send_file(steady);
            files_sent++;
            if (files_sent == 8 || $urandom_range(0, 7) == 0) begin
                // pause until the block has drained
                idle_cycles(1);
                while (parsed_bytes_q.size() != 0) @(posedge aclk);
            end
        end
        idle_cycles(1);

        drain = 0;
        while (parsed_bytes_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4) @(posedge aclk);
        if (parsed_bytes_q.size() != 0) begin
            $display("%0d results never arrived", parsed_bytes_q.size());
            mismatches += parsed_bytes_q.size();
        end

        $display("covered %0d files in %0d bytes, %0d audio bytes, %0d long receiver hold-offs",
                 files_sent, bytes_in, audio_seen, holds_done);
        $display("verdicts: ok %0d, not riff/wave %0d, missing chunk %0d, bad format %0d, truncated %0d",
                 verdict_seen[ST_OK], verdict_seen[ST_NOT_WAVE], verdict_seen[ST_MISSING],
                 verdict_seen[ST_BAD_FORMAT], verdict_seen[ST_TRUNCATED]);
        if (mismatches == 0) begin
            $display("wav_riff_header_parser: match");
        end else begin
            $display("wav_riff_header_parser: mismatch");
        end
        $finish;
    end

endmodule
